FILE: hw/rtl/nnsb_pkg.sv
// ----------------------------------------------------------------------------
// nnsb_pkg: shared definitions for the nearest-neighbor scale blit
// Coordinate width default, register index codes and the flag group that
// travels alongside each pixel through the pipeline.
// ----------------------------------------------------------------------------
package nnsb_pkg;

  // Default coordinate width; the top level takes it as a parameter.
  localparam int COORD_BITS = 12;

  // Configuration register index codes.
  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_X      = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_Y      = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd7;

  // Per-pixel flags: inside the destination rectangle, and final write flag.
  typedef struct packed {
    logic in_rect;
    logic wr;
  } flags_t;

endpackage

FILE: hw/rtl/nnsb_div.sv
// ----------------------------------------------------------------------------
// nnsb_div: pipelined restoring divider
// One quotient bit per stage, COORD_BITS+1 stages. The quotient is assumed
// to fit in COORD_BITS+1 bits (dividend below divisor shifted by that much).
// ----------------------------------------------------------------------------
module nnsb_div #(
  parameter int COORD_BITS = nnsb_pkg::COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [2*COORD_BITS:0]   dividend,
  input  logic [COORD_BITS:0]     divisor,
  output logic                    out_valid,
  output logic [COORD_BITS:0]     quotient
);

  localparam int RW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 1;
  localparam int QB = RW;

  logic [QB-1:0] valid;
  logic [RW-1:0] rem [QB];
  logic [QB-1:0] dvd [QB];
  logic [QB-1:0] quo [QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[QB-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] r_in;
    logic [QB-1:0] d_in;
    logic [QB-1:0] q_in;
    logic [RW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = {1'b0, dividend[PW-1:QB]};
      assign d_in = dividend[QB-1:0];
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[k-1];
      assign d_in = dvd[k-1];
      assign q_in = quo[k-1];
    end

    assign trial = {r_in, d_in[QB-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
        dvd[k] <= {d_in[QB-2:0], 1'b0};
        quo[k] <= {q_in[QB-2:0], ge};
      end
    end
  end

  assign out_valid = valid[QB-1];
  assign quotient  = quo[QB-1];

endmodule

FILE: hw/rtl/nnsb_index.sv
// ----------------------------------------------------------------------------
// nnsb_index: saturation and linear source index
// Stage A clamps the quotients and multiplies row by source width; stage B
// adds the column, clamps the index and holds the result for the output.
// ----------------------------------------------------------------------------
module nnsb_index #(
  parameter int COORD_BITS = nnsb_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [COORD_BITS:0]          q_col,
  input  logic [COORD_BITS:0]          q_row,
  input  logic [COORD_BITS:0]          sw,
  input  nnsb_pkg::flags_t             flags,
  input  logic signed [COORD_BITS+1:0] fb_col_in,
  input  logic signed [COORD_BITS+1:0] fb_row_in,
  output logic                         out_valid,
  output logic [COORD_BITS-1:0]        src_col,
  output logic [COORD_BITS-1:0]        src_row,
  output logic [2*COORD_BITS-1:0]      src_index,
  output logic signed [COORD_BITS+1:0] fb_col,
  output logic signed [COORD_BITS+1:0] fb_row,
  output logic                         write_enable
);

  localparam int C  = COORD_BITS;
  localparam int PW = 2 * COORD_BITS + 1;
  localparam int SW = 2 * COORD_BITS + 2;

  // stage A
  logic [C-1:0]         sc;
  logic [C-1:0]         sr;
  logic                 a_valid;
  logic [C-1:0]         a_sc;
  logic [C-1:0]         a_sr;
  logic [PW-1:0]        a_prod;
  logic signed [C+1:0]  a_fb_col;
  logic signed [C+1:0]  a_fb_row;
  logic                 a_wr;
  // stage B
  logic [SW-1:0]        sum;

  // clamp to the coordinate range; zero outside the rectangle
  assign sc = !flags.in_rect ? '0 : (q_col[C] ? '1 : q_col[C-1:0]);
  assign sr = !flags.in_rect ? '0 : (q_row[C] ? '1 : q_row[C-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sc     <= sc;
      a_sr     <= sr;
      a_prod   <= PW'(sr) * PW'(sw);
      a_fb_col <= fb_col_in;
      a_fb_row <= fb_row_in;
      a_wr     <= flags.wr;
    end
  end

  assign sum = {1'b0, a_prod} + SW'(a_sc);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src_col      <= a_sc;
      src_row      <= a_sr;
      src_index    <= (sum[SW-1:2*C] != '0) ? '1 : sum[2*C-1:0];
      fb_col       <= a_fb_col;
      fb_row       <= a_fb_row;
      write_enable <= a_wr;
    end
  end

endmodule

FILE: hw/rtl/nearest_neighbor_scale_blit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_blit: nearest-neighbor scaling address generator
// Maps a destination pixel position inside a blit rectangle to its source
// column, row and linear index, plus framebuffer coordinates and a clipped
// write flag.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+----------------------
//  input    | target_col, target_row                    | in_valid & in_ready
//  output   | src_col, src_row, src_index, fb_col,      | out_valid & out_ready
//           | fb_row, write_enable                      |
//  config   | cfg_index, cfg_data                       | cfg_wen
//
//  One pixel per cycle sustained while the output is taken. Stages in order:
//  input/multiply stage, COORD_BITS+1 divider stages (one quotient bit each),
//  index multiply stage, index add/output stage.
//  The whole pipeline advances together; it holds when the output register
//  is full and not taken, and in_ready drops for that cycle.
//  Synchronous reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_blit #(
  parameter int COORD_BITS = nnsb_pkg::COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [COORD_BITS-1:0]             target_col,
  input  logic [COORD_BITS-1:0]             target_row,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COORD_BITS-1:0]             src_col,
  output logic [COORD_BITS-1:0]             src_row,
  output logic [2*COORD_BITS-1:0]           src_index,
  output logic signed [COORD_BITS+1:0]      fb_col,
  output logic signed [COORD_BITS+1:0]      fb_row,
  output logic                              write_enable,
  // configuration write port
  input  logic                              cfg_wen,
  input  logic [nnsb_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS:0]               cfg_data
);

  localparam int RW = COORD_BITS + 1;      // register width
  localparam int FW = COORD_BITS + 2;      // framebuffer coordinate width
  localparam int PW = 2 * COORD_BITS + 1;  // product width
  localparam int QB = COORD_BITS + 1;      // divider depth

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RW-1:0] source_width;
  logic [RW-1:0] source_height;
  logic [RW-1:0] target_width;
  logic [RW-1:0] target_height;
  logic [RW-1:0] origin_x;
  logic [RW-1:0] origin_y;
  logic [RW-1:0] screen_width;
  logic [RW-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RW'(1);
      source_height <= RW'(1);
      target_width  <= RW'(1);
      target_height <= RW'(1);
      origin_x      <= '0;
      origin_y      <= '0;
      screen_width  <= RW'(1);
      screen_height <= RW'(1);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        nnsb_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        nnsb_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data;
        nnsb_pkg::REG_TARGET_WIDTH:  target_width  <= cfg_data;
        nnsb_pkg::REG_TARGET_HEIGHT: target_height <= cfg_data;
        nnsb_pkg::REG_ORIGIN_X:      origin_x      <= cfg_data;
        nnsb_pkg::REG_ORIGIN_Y:      origin_y      <= cfg_data;
        nnsb_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        nnsb_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: everything moves unless the output is full and stalled
  // --------------------------------------------------------------------------
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: framebuffer coordinates, clipping, scale products
  // --------------------------------------------------------------------------
  logic signed [FW-1:0] fx;
  logic signed [FW-1:0] fy;
  logic                 in_rect;
  logic                 on_fb;

  assign fx = $signed({origin_x[RW-1], origin_x}) + $signed({2'b00, target_col});
  assign fy = $signed({origin_y[RW-1], origin_y}) + $signed({2'b00, target_row});

  // a nonnegative coordinate fits in RW bits, so the low bits compare directly
  assign in_rect = ({1'b0, target_col} < target_width) &&
                   ({1'b0, target_row} < target_height);
  assign on_fb   = !fx[FW-1] && !fy[FW-1] &&
                   (fx[RW-1:0] < screen_width) && (fy[RW-1:0] < screen_height);

  logic                 s1_valid;
  logic [PW-1:0]        s1_prod_col;
  logic [PW-1:0]        s1_prod_row;
  logic signed [FW-1:0] s1_fb_col;
  logic signed [FW-1:0] s1_fb_row;
  nnsb_pkg::flags_t     s1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_col      <= PW'(target_col) * PW'(source_width);
      s1_prod_row      <= PW'(target_row) * PW'(source_height);
      s1_fb_col        <= fx;
      s1_fb_row        <= fy;
      s1_flags.in_rect <= in_rect;
      s1_flags.wr      <= in_rect && on_fb;
    end
  end

  // --------------------------------------------------------------------------
  // Divider lanes (column and row) and the side line that matches their depth
  // --------------------------------------------------------------------------
  logic          col_valid;
  logic          row_valid;
  logic [RW-1:0] q_col;
  logic [RW-1:0] q_row;

  nnsb_div #(.COORD_BITS(COORD_BITS)) u_div_col (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .dividend  (s1_prod_col),
    .divisor   (target_width),
    .out_valid (col_valid),
    .quotient  (q_col)
  );

  nnsb_div #(.COORD_BITS(COORD_BITS)) u_div_row (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .dividend  (s1_prod_row),
    .divisor   (target_height),
    .out_valid (row_valid),
    .quotient  (q_row)
  );

  nnsb_pkg::flags_t     sd_flags  [QB];
  logic signed [FW-1:0] sd_fb_col [QB];
  logic signed [FW-1:0] sd_fb_row [QB];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_flags[0]  <= s1_flags;
      sd_fb_col[0] <= s1_fb_col;
      sd_fb_row[0] <= s1_fb_row;
      for (int i = 1; i < QB; i++) begin
        sd_flags[i]  <= sd_flags[i-1];
        sd_fb_col[i] <= sd_fb_col[i-1];
        sd_fb_row[i] <= sd_fb_row[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Clamp, index multiply-add and output register
  // --------------------------------------------------------------------------
  nnsb_index #(.COORD_BITS(COORD_BITS)) u_index (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (col_valid),
    .q_col        (q_col),
    .q_row        (q_row),
    .sw           (source_width),
    .flags        (sd_flags[QB-1]),
    .fb_col_in    (sd_fb_col[QB-1]),
    .fb_row_in    (sd_fb_row[QB-1]),
    .out_valid    (out_valid),
    .src_col      (src_col),
    .src_row      (src_row),
    .src_index    (src_index),
    .fb_col       (fb_col),
    .fb_row       (fb_row),
    .write_enable (write_enable)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    col_valid == row_valid)
    else $error("column and row divider lanes out of step");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_write_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> !fb_col[FW-1] && !fb_row[FW-1])
    else $error("write flagged at negative framebuffer coordinate");

endmodule

FILE: sim/nearest_neighbor_scale_blit_tb.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_blit_tb: self-checking bench for the scale blit
// Drives destination pixel positions through the valid/ready input channel
// under a series of blit geometries. A scoreboard predicts the source
// coordinates, source index, framebuffer position and write flag of every
// transfer and compares them, in order, with what the output channel returns.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_blit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = nnsb_pkg::COORD_BITS;
  localparam int IB = nnsb_pkg::REG_IDX_BITS;
  localparam int RB = CB + 1;          // register width
  localparam int LATENCY = CB + 4;     // pipeline depth from the block header
  localparam int CYCLE_LIMIT = 300000; // far above the slowest legal run
  localparam int RANDOM_SEGMENTS = 12;
  localparam int ITEMS_PER_SEGMENT = 111;

  // One output transfer.
  typedef struct {
    logic [CB-1:0]          src_col;
    logic [CB-1:0]          src_row;
    logic [2*CB-1:0]        src_index;
    logic signed [CB+1:0]   fb_col;
    logic signed [CB+1:0]   fb_row;
    logic                   write_enable;
  } pixel_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the geometry registers, predicts each
  // accepted position and checks results in arrival order.
  // --------------------------------------------------------------------------
  class blit_scoreboard;
    logic [RB-1:0]        src_w, src_h, dst_w, dst_h, scr_w, scr_h;
    logic signed [RB-1:0] org_x, org_y;
    pixel_t               expected_pixels[$];
    int                   errors;
    int                   accepted;

    function new();
      src_w = 1; src_h = 1; dst_w = 1; dst_h = 1;
      org_x = 0; org_y = 0; scr_w = 1; scr_h = 1;
      errors = 0;
      accepted = 0;
    endfunction

    function void set_reg(logic [IB-1:0] idx, logic [RB-1:0] v);
      case (idx)
        nnsb_pkg::REG_SOURCE_WIDTH:  src_w = v;
        nnsb_pkg::REG_SOURCE_HEIGHT: src_h = v;
        nnsb_pkg::REG_TARGET_WIDTH:  dst_w = v;
        nnsb_pkg::REG_TARGET_HEIGHT: dst_h = v;
        nnsb_pkg::REG_ORIGIN_X:      org_x = v;
        nnsb_pkg::REG_ORIGIN_Y:      org_y = v;
        nnsb_pkg::REG_SCREEN_WIDTH:  scr_w = v;
        nnsb_pkg::REG_SCREEN_HEIGHT: scr_h = v;
        default: ;
      endcase
    endfunction

    // Truncating scale, clamped to the coordinate range.
    function longint scale(longint pos, longint num, longint den);
      longint q;
      if (den == 0) return 0;
      q = pos * num / den;
      return (q > (1 << CB) - 1) ? (1 << CB) - 1 : q;
    endfunction

    function void note_pixel(logic [CB-1:0] tc, logic [CB-1:0] tr);
      pixel_t e;
      longint fx, fy, sc, sr, si;
      bit     in_rect, on_fb;
      fx = longint'(org_x) + longint'(tc);
      fy = longint'(org_y) + longint'(tr);
      in_rect = (tc < dst_w) && (tr < dst_h);
      on_fb = fx >= 0 && fy >= 0 && fx < longint'(scr_w) && fy < longint'(scr_h);
      sc = 0; sr = 0; si = 0;
      if (in_rect) begin
        sc = scale(tc, src_w, dst_w);
        sr = scale(tr, src_h, dst_h);
        si = sr * longint'(src_w) + sc;
        if (si > (longint'(1) << (2 * CB)) - 1) si = (longint'(1) << (2 * CB)) - 1;
      end
      e.src_col = sc[CB-1:0];
      e.src_row = sr[CB-1:0];
      e.src_index = si[2*CB-1:0];
      e.fb_col = fx[CB+1:0];
      e.fb_row = fy[CB+1:0];
      e.write_enable = in_rect && on_fb;
      expected_pixels.push_back(e);
      accepted++;
    endfunction

    function void compare(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t e;
      if (expected_pixels.size() == 0) begin
        $error("result transfer with no pixel outstanding");
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      compare("src_col", e.src_col, got.src_col);
      compare("src_row", e.src_row, got.src_row);
      compare("src_index", e.src_index, got.src_index);
      compare("fb_col", longint'(e.fb_col), longint'(got.fb_col));
      compare("fb_row", longint'(e.fb_row), longint'(got.fb_row));
      compare("write_enable", e.write_enable, got.write_enable);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CB-1:0]              target_col = '0;
  logic [CB-1:0]              target_row = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [CB-1:0]              src_col;
  logic [CB-1:0]              src_row;
  logic [2*CB-1:0]            src_index;
  logic signed [CB+1:0]       fb_col;
  logic signed [CB+1:0]       fb_row;
  logic                       write_enable;
  logic                       cfg_wen = 1'b0;
  logic [IB-1:0]              cfg_index = '0;
  logic [RB-1:0]              cfg_data = '0;

  blit_scoreboard sb = new();

  // Idle profile: 0 = sender 25% / receiver 80%, 1 = swapped, 2 = no idling.
  int          idle_mode = 0;
  // Current rectangle size, used to aim positions near its edges.
  logic [RB-1:0] cur_tw = 1;
  logic [RB-1:0] cur_th = 1;
  int unsigned cycle_count = 0;

  nearest_neighbor_scale_blit #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .target_col(target_col), .target_row(target_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .src_col(src_col), .src_row(src_row), .src_index(src_index),
    .fb_col(fb_col), .fb_row(fb_row), .write_enable(write_enable),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Monitors sample at the edge, before this edge's updates land.
  always @(posedge clk) begin
    pixel_t got;
    if (!rst && in_valid && in_ready) sb.note_pixel(target_col, target_row);
    if (!rst && out_valid && out_ready) begin
      got.src_col = src_col;
      got.src_row = src_row;
      got.src_index = src_index;
      got.fb_col = fb_col;
      got.fb_row = fb_row;
      got.write_enable = write_enable;
      sb.check_pixel(got);
    end
  end

  // Receiver: random backpressure, plus one long hold-off once a couple of
  // hundred pixels are in so the pipeline fills and in_ready drops.
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    int stall_pct;
    stall_pct = (idle_mode == 0) ? 80 : (idle_mode == 1) ? 25 : 0;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sb.accepted >= 200) begin
      out_ready <= 1'b0;
      hold_left <= 4 * LATENCY;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // One input transfer; valid stays up across back-to-back transfers.
  task automatic send_pixel(input logic [CB-1:0] tc, input logic [CB-1:0] tr);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 25 : (idle_mode == 1) ? 80 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    target_col <= tc;
    target_row <= tr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every outstanding pixel has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IB-1:0] idx, input logic [RB-1:0] v);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // Full geometry update, only with the pipeline empty.
  task automatic configure(input logic [RB-1:0] sw, sh, tw, th, ox, oy, scw, sch);
    drain();
    write_reg(nnsb_pkg::REG_SOURCE_WIDTH, sw);
    write_reg(nnsb_pkg::REG_SOURCE_HEIGHT, sh);
    write_reg(nnsb_pkg::REG_TARGET_WIDTH, tw);
    write_reg(nnsb_pkg::REG_TARGET_HEIGHT, th);
    write_reg(nnsb_pkg::REG_ORIGIN_X, ox);
    write_reg(nnsb_pkg::REG_ORIGIN_Y, oy);
    write_reg(nnsb_pkg::REG_SCREEN_WIDTH, scw);
    write_reg(nnsb_pkg::REG_SCREEN_HEIGHT, sch);
    cfg_wen <= 1'b0;
    cur_tw = tw;
    cur_th = th;
  endtask

  // Sizes: mostly legal, with the ends of the range, zero and oversize values.
  function automatic logic [RB-1:0] pick_size();
    case ($urandom_range(0, 19))
      0: return RB'(1);
      1: return RB'(4096);
      2: return RB'($urandom_range(4097, (1 << RB) - 1));
      3: return '0;
      4, 5, 6, 7, 8, 9: return RB'($urandom_range(1, 4096));
      default: return RB'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [RB-1:0] pick_origin();
    case ($urandom_range(0, 9))
      0: return 13'h1000; // most negative
      1: return 13'h0fff; // most positive
      2, 3, 4, 5: return RB'($urandom_range(0, (1 << RB) - 1));
      default: return RB'($urandom_range(0, 16) - 8);
    endcase
  endfunction

  // Positions mostly inside the rectangle or one past its edge.
  function automatic logic [CB-1:0] pick_pos(logic [RB-1:0] extent);
    if ($urandom_range(0, 4) == 0) return CB'($urandom_range(0, (1 << CB) - 1));
    return CB'($urandom_range(0, (extent >= (1 << CB) - 1) ? (1 << CB) - 1 : extent));
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: a 1x1 blit onto a 1x1 screen.
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(12'hfff, 12'hfff);

    // Full-size identity blit: largest source index, last on-screen pixel.
    configure(4096, 4096, 4096, 4096, 0, 0, 4096, 4096);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(0, 12'hfff);
    send_pixel(12'hfff, 0);
    send_pixel(2048, 1);
    send_pixel(12'haaa, 12'h555);

    // Magnify a 1x1 source, rectangle pushed fully off the top-left.
    configure(1, 1, 4096, 4096, 13'h1000, 13'h1000, 1, 1);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(0, 0);
    send_pixel(12'h555, 12'haaa);

    // Oversize source registers: coordinate and index saturation.
    configure(13'h1fff, 13'h1fff, 3, 3, 13'h0fff, 13'h0fff, 13'h1fff, 13'h1fff);
    send_pixel(2, 2);
    send_pixel(1, 1);
    send_pixel(3, 0);

    // Zero-size rectangle and screen: nothing is ever written.
    configure(0, 0, 0, 0, 0, 0, 0, 0);
    send_pixel(0, 0);
    send_pixel(5, 5);

    // Magnify with clipping exactly at the screen's right and bottom edges.
    configure(64, 48, 200, 100, 100, -50, 200, 49);
    send_pixel(99, 99);
    send_pixel(100, 98);
    send_pixel(99, 98);
    send_pixel(199, 99);

    // Random geometries, three idle profiles in turn.
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      configure(pick_size(), pick_size(), pick_size(), pick_size(),
                pick_origin(), pick_origin(), pick_size(), pick_size());
      idle_mode = seg / (RANDOM_SEGMENTS / 3);
      repeat (ITEMS_PER_SEGMENT) send_pixel(pick_pos(cur_tw), pick_pos(cur_th));
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
